// File: hdl/sril_pkg.sv
// ----------------------------------------------------------------------------
// sril_pkg: shared types and constants for the sorted reminder list
// Entry layout, status codes, key limits and cell control groups.
// ----------------------------------------------------------------------------
package sril_pkg;

   // number of cells in the chain
   localparam int DEPTH = 32;
   // width of the fill count, able to hold DEPTH itself
   localparam int CNT_W = $clog2(DEPTH + 1);

   // key limits
   localparam logic [4:0] MAX_DAY    = 5'd31;
   localparam logic [4:0] MAX_HOUR   = 5'd23;
   localparam logic [5:0] MAX_MINUTE = 6'd59;

   // result status codes
   typedef enum logic [2:0] {
      ST_STORED  = 3'd0,
      ST_INVALID = 3'd1,
      ST_FULL    = 3'd2,
      ST_LISTED  = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   // one stored entry; the low 16 bits form the sort key
   typedef struct packed {
      logic [15:0] tag;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
   } entry_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic ins;   // insert the new entry this cycle
      logic rot;   // rotate occupied entries one place toward the head
   } cell_cmd_type;

   // position of one cell relative to the fill count
   typedef struct packed {
      logic occ;      // cell holds a live entry
      logic at_end;   // first free cell
      logic at_tail;  // last live cell
   } cell_ctl_type;

   // sort key of an entry
   function automatic logic [15:0] entry_key(entry_type e);
      return {e.day, e.hour, e.minute};
   endfunction

endpackage

// File: hdl/sril_cell.sv
// ----------------------------------------------------------------------------
// sril_cell: one compare-and-shift cell of the sorted chain
// Holds one entry; on insert it keeps, takes the new entry or takes its
// upstream neighbor; on rotate it takes its downstream neighbor, or the head entry if it is the tail.
// ----------------------------------------------------------------------------
module sril_cell (
   input  logic                  clock,
   input  sril_pkg::cell_cmd_type cmd,
   input  sril_pkg::cell_ctl_type ctl,
   input  sril_pkg::entry_type    new_word,
   input  sril_pkg::entry_type    prev_word,
   input  logic                  prev_gt,
   input  sril_pkg::entry_type    next_word,
   input  sril_pkg::entry_type    head_word,
   output sril_pkg::entry_type    word,
   output logic                  gt
);
   import sril_pkg::*;

   entry_type word_ff;
   entry_type word_in;

   // live entry with a strictly larger key: the new entry goes before it
   assign gt   = ctl.occ && (entry_key(word_ff) > entry_key(new_word));
   assign word = word_ff;

   always_comb begin
      word_in = word_ff;
      if (cmd.ins) begin
         if (prev_gt) begin
            word_in = prev_word;
         end else if (gt || ctl.at_end) begin
            word_in = new_word;
         end
      end else if (cmd.rot && ctl.occ) begin
         word_in = ctl.at_tail ? head_word : next_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

// File: hdl/sorted_reminder_insert_list.sv
// ----------------------------------------------------------------------------
// sorted_reminder_insert_list: sorted table of reminders keyed by day/hour/minute
// Chain of compare-and-shift cells with a small list sequencer.
// ----------------------------------------------------------------------------
// usage
//   req_* carries one item: an insert (action 0, day 1..31) or a list
//   request (action 1, or day 0). rsp_* returns results, each a status,
//   an entry and a last flag; both channels use valid/stall.
//   an insert gives one result in the cycle after acceptance: stored, invalid
//   key (checked first) or table full. the chain of DEPTH cells places the
//   entry after all entries with an equal key, as the result is registered.
//   a list request on an empty table gives one empty result; otherwise the
//   entries come out one per cycle in key order, last flag on the final one.
//   the head cell feeds the output and the chain rotates one place per
//   entry, so after the list the table is back in its original order.
//   throughput: one insert per cycle; req_stall is high while a list drains.
//   a stalled result holds in the output register; the block then takes
//   no new item and pauses any list in progress.
//   reset clears the fill count, the sequencer and the output valid;
//   entry contents are not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_reminder_insert_list (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [4:0]  req_day,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [15:0] req_tag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_out_day,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [15:0] rsp_out_tag,
   output logic        rsp_last
);
   import sril_pkg::*;

   // sequencer states, one-hot
   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_LIST = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;     // entries emitted so far in a list

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   entry_type        data_ff, data_in;
   logic             last_ff, last_in;

   logic             out_free;
   logic             req_acc;
   logic             is_list;
   logic             key_bad;
   logic             full;
   logic             ins_go;
   logic             list_step;
   logic             list_last;
   entry_type        new_word;
   cell_cmd_type     cmd;

   // chain wiring
   entry_type        word_w [DEPTH];
   logic             gt_w   [DEPTH];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign req_acc   = req_valid && !req_stall;

   // day 0 on an insert means list
   assign is_list = req_action || (req_day == 5'd0);
   assign key_bad = (req_day > MAX_DAY) || (req_hour > MAX_HOUR) ||
                    (req_minute > MAX_MINUTE);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign ins_go  = req_acc && !is_list && !key_bad && !full;

   assign list_step = (state_ff == S_LIST) && out_free;
   assign list_last = ((idx_ff + CNT_W'(1)) == count_ff);

   assign new_word = '{tag: req_tag, day: req_day, hour: req_hour, minute: req_minute};
   assign cmd      = '{ins: ins_go, rot: list_step};

   // cell chain: each cell sees its neighbors and where it sits vs. the count
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctl_type ctl;
      entry_type    prev_word;
      logic         prev_gt;
      entry_type    next_word;

      assign ctl.occ     = (CNT_W'(i) < count_ff);
      assign ctl.at_end  = (CNT_W'(i) == count_ff);
      assign ctl.at_tail = (CNT_W'(i + 1) == count_ff);

      if (i == 0) begin : g_head
         assign prev_word = new_word;
         assign prev_gt   = 1'b0;
      end else begin : g_body
         assign prev_word = word_w[i-1];
         assign prev_gt   = gt_w[i-1];
      end

      // the final cell is only ever the tail when it rotates
      if (i == DEPTH - 1) begin : g_last
         assign next_word = word_w[0];
      end else begin : g_mid
         assign next_word = word_w[i+1];
      end

      sril_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .ctl       (ctl),
         .new_word  (new_word),
         .prev_word (prev_word),
         .prev_gt   (prev_gt),
         .next_word (next_word),
         .head_word (word_w[0]),
         .word      (word_w[i]),
         .gt        (gt_w[i])
      );
   end

   // sequencer and output register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      data_in      = data_ff;
      last_in      = last_ff;

      // a taken result frees the register unless refilled below
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               data_in = '0;
               last_in = 1'b1;
               if (is_list) begin
                  if (count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     status_in    = ST_EMPTY;
                  end else begin
                     idx_in   = '0;
                     state_in = S_LIST;
                  end
               end else if (key_bad) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_INVALID;
               end else if (full) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_FULL;
               end else begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_STORED;
                  count_in     = count_ff + CNT_W'(1);
               end
            end
         end
         S_LIST: begin
            // head cell goes out while the chain rotates under it
            if (list_step) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_LISTED;
               data_in      = word_w[0];
               last_in      = list_last;
               idx_in       = idx_ff + CNT_W'(1);
               if (list_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      data_ff   <= data_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_out_day    = data_ff.day;
   assign rsp_out_hour   = data_ff.hour;
   assign rsp_out_minute = data_ff.minute;
   assign rsp_out_tag    = data_ff.tag;
   assign rsp_last       = last_ff;

endmodule
